/* hdl/mff_pkg.sv */
// ----------------------------------------------------------------------------
// mff_pkg
// Shared types, constants and filter helper functions for the measurement
// frame filter.
// ----------------------------------------------------------------------------
package mff_pkg;

    localparam int VALUE_BITS    = 16;
    localparam int SHORT_LEN     = 3;
    localparam int LONG_LEN      = 5;
    localparam int SMOOTH_SHIFT  = 4;
    localparam int CHANNELS      = 2;
    localparam int WARMUP_BITS   = 8;

    localparam logic [WARMUP_BITS-1:0] WARMUP_RESET = 8'd10;

    typedef logic [VALUE_BITS-1:0]  value_t;
    typedef logic [WARMUP_BITS-1:0] warmup_t;
    typedef value_t [LONG_LEN-1:0]  window_t;

    localparam logic [VALUE_BITS:0] ROUND_ADD = (VALUE_BITS+1)'((1 << SMOOTH_SHIFT) - 1);

    typedef struct packed {
        logic   frame_ok;
        value_t current_one_ma;
        value_t current_two_ma;
        value_t supply_in_mv;
        value_t pack_full_mv;
        value_t pack_half_mv;
        logic   supply_present;
    } frame_t;

    typedef struct packed {
        value_t current_one_out;
        value_t current_two_out;
        value_t supply_out;
        value_t pack_full_out;
        value_t pack_half_out;
        value_t lower_half_out;
        value_t upper_half_out;
        logic   presence_out;
        logic   data_valid;
    } result_t;

    function automatic value_t mid3(value_t a, value_t b, value_t c);
        value_t lo;
        value_t hi;
        value_t m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // Rank every entry (ties broken by position) and pick the middle rank.
    function automatic value_t mid5(window_t w);
        value_t     m;
        logic [2:0] rank;
        m = '0;
        for (int i = 0; i < LONG_LEN; i++)
        begin
            rank = '0;
            for (int j = 0; j < LONG_LEN; j++)
            begin
                if (j != i)
                begin
                    if ((w[j] < w[i]) || ((w[j] == w[i]) && (j < i)))
                        rank = rank + 3'd1;
                end
            end
            if (rank == 3'(LONG_LEN / 2))
                m = w[i];
        end
        return m;
    endfunction

    // Move toward the sample by the rounded-up difference over 2^SMOOTH_SHIFT.
    function automatic value_t smooth(value_t prev, value_t sample);
        logic [VALUE_BITS:0] diff;
        value_t              step;
        if (sample >= prev)
            diff = {1'b0, sample - prev};
        else
            diff = {1'b0, prev - sample};
        step = VALUE_BITS'((diff + ROUND_ADD) >> SMOOTH_SHIFT);
        return (sample >= prev) ? (prev + step) : (prev - step);
    endfunction

endpackage

/* hdl/mff_stream_if.sv */
// ----------------------------------------------------------------------------
// mff_stream_if
// Valid/ready channel carrying one request payload per accepted transfer.
// ----------------------------------------------------------------------------
interface mff_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

/* hdl/mff_filter.sv */
// ----------------------------------------------------------------------------
// mff_filter
// Filter state and single-pass datapath: median-of-three plus low-pass on the
// currents, median-of-five on the battery halves, warm-up count.
// ----------------------------------------------------------------------------
module mff_filter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  mff_pkg::frame_t  item,
    input  mff_pkg::warmup_t warmup_frames,
    output mff_pkg::result_t result
);

    mff_pkg::warmup_t warmup_count_reg;
    mff_pkg::warmup_t warmup_count_next;
    mff_pkg::value_t  smooth_reg    [mff_pkg::CHANNELS];
    mff_pkg::value_t  smooth_next   [mff_pkg::CHANNELS];
    mff_pkg::value_t  short_hist_reg[mff_pkg::CHANNELS][mff_pkg::SHORT_LEN];
    mff_pkg::value_t  long_hist_reg [mff_pkg::CHANNELS][mff_pkg::LONG_LEN];
    mff_pkg::value_t  cur_in        [mff_pkg::CHANNELS];
    mff_pkg::value_t  volt_in       [mff_pkg::CHANNELS];
    mff_pkg::value_t  volt_med      [mff_pkg::CHANNELS];
    mff_pkg::window_t window        [mff_pkg::CHANNELS];
    mff_pkg::result_t pub_reg;
    mff_pkg::result_t pub_next;

    always_comb
    begin
        cur_in[0]  = item.current_one_ma;
        cur_in[1]  = item.current_two_ma;
        volt_in[0] = item.pack_half_mv;
        volt_in[1] = (item.pack_full_mv >= item.pack_half_mv)
                   ? (item.pack_full_mv - item.pack_half_mv) : '0;

        for (int ch = 0; ch < mff_pkg::CHANNELS; ch++)
        begin
            smooth_next[ch] = mff_pkg::smooth(smooth_reg[ch],
                mff_pkg::mid3(short_hist_reg[ch][1], short_hist_reg[ch][2], cur_in[ch]));
            for (int k = 0; k < mff_pkg::LONG_LEN - 1; k++)
                window[ch][k] = long_hist_reg[ch][k+1];
            window[ch][mff_pkg::LONG_LEN-1] = volt_in[ch];
            volt_med[ch] = mff_pkg::mid5(window[ch]);
        end

        if (!item.frame_ok)
            warmup_count_next = '0;
        else if (warmup_count_reg < warmup_frames)
            warmup_count_next = warmup_count_reg + 8'd1;
        else
            warmup_count_next = warmup_count_reg;

        pub_next.current_one_out = smooth_next[0];
        pub_next.current_two_out = smooth_next[1];
        pub_next.supply_out      = item.supply_in_mv;
        pub_next.pack_full_out   = item.pack_full_mv;
        pub_next.pack_half_out   = item.pack_half_mv;
        pub_next.lower_half_out  = volt_med[0];
        pub_next.upper_half_out  = volt_med[1];
        pub_next.presence_out    = item.supply_present;
        pub_next.data_valid      = 1'b0;

        // Missing frame: repeat the held values with valid low.
        if (item.frame_ok)
        begin
            result            = pub_next;
            result.data_valid = (warmup_count_next >= warmup_frames);
        end
        else
        begin
            result            = pub_reg;
            result.data_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_count_reg <= '0;
            pub_reg          <= '0;
            for (int ch = 0; ch < mff_pkg::CHANNELS; ch++)
            begin
                smooth_reg[ch] <= '0;
                for (int k = 0; k < mff_pkg::SHORT_LEN; k++)
                    short_hist_reg[ch][k] <= '0;
                for (int k = 0; k < mff_pkg::LONG_LEN; k++)
                    long_hist_reg[ch][k] <= '0;
            end
        end
        else if (advance)
        begin
            warmup_count_reg <= warmup_count_next;
            if (item.frame_ok)
            begin
                pub_reg <= pub_next;
                for (int ch = 0; ch < mff_pkg::CHANNELS; ch++)
                begin
                    smooth_reg[ch] <= smooth_next[ch];
                    for (int k = 0; k < mff_pkg::SHORT_LEN - 1; k++)
                        short_hist_reg[ch][k] <= short_hist_reg[ch][k+1];
                    short_hist_reg[ch][mff_pkg::SHORT_LEN-1] <= cur_in[ch];
                    for (int k = 0; k < mff_pkg::LONG_LEN; k++)
                        long_hist_reg[ch][k] <= window[ch][k];
                end
            end
        end
    end

    a_missing_clears_warmup: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && !item.frame_ok |=> warmup_count_reg == '0
    ) else $error("warm-up count not cleared by missing frame");

    a_warmup_rises: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && item.frame_ok && (warmup_count_reg < warmup_frames)
        |=> warmup_count_reg == $past(warmup_count_reg) + 8'd1
    ) else $error("warm-up count did not advance on good frame");

    a_hold_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pub_reg) && $stable(warmup_count_reg)
    ) else $error("filter state moved without a request");

endmodule

/* hdl/measurement_frame_filter.sv */
// ----------------------------------------------------------------------------
// measurement_frame_filter
// Frame filter top level: input register, filter datapath, result register.
// ----------------------------------------------------------------------------
// Path: an accepted frame waits in the input register, then passes the filter
//   into the result register once that register is empty or being taken.
// Throughput: one frame per cycle while the result is not stalled; the filter
//   stage is a single pass between the input and result registers.
// Reset: rst_n clears all filter history, published values and the warm-up
//   count to zero and sets warmup_frames to 10.
module measurement_frame_filter (
    input  logic                    clk,
    input  logic                    rst_n,
    mff_stream_if.sink              frame,
    mff_stream_if.source            result,
    input  logic                    cfg_we,
    input  logic [mff_pkg::WARMUP_BITS-1:0] cfg_wdata
);

    mff_pkg::warmup_t warmup_frames_reg;
    mff_pkg::frame_t  frame_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    mff_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    mff_pkg::result_t filt_result;
    logic             advance;
    logic             take;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready  = !s1_valid_reg || advance;
    assign take         = frame.valid && frame.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    mff_filter u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (frame_reg),
        .warmup_frames (warmup_frames_reg),
        .result        (filt_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_frames_reg <= mff_pkg::WARMUP_RESET;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                warmup_frames_reg <= cfg_wdata;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            frame_reg <= frame.payload;
        if (advance)
            out_reg <= filt_result;
    end

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        take |-> !(s1_valid_reg && !advance)
    ) else $error("held request overwritten");

    a_drain_to_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg
    ) else $error("request stuck with result register empty");

    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.payload)
    ) else $error("stalled result changed or dropped");

endmodule
